@@ hdl/sfba_pkg.sv @@
`default_nettype none
package sfba_pkg;

    localparam int SMALL_CLASSES_DEF   = 31;
    localparam int LARGE_CLASSES_DEF   = 8;
    localparam int LARGE_FIRST_EXP_DEF = 5;
    localparam int LIST_DEPTH_DEF      = 16;
    localparam int ADDR_BITS_DEF       = 20;

    localparam int FIELD_BITS = 20;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EMPTY = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_FIT  = 2'd1;
    localparam logic [1:0] ST_DROPPED = 2'd2;

endpackage
`default_nettype wire

@@ hdl/sfba_list_mem.sv @@
`default_nettype none
module sfba_list_mem #(
    parameter int ROWS  = 16,
    parameter int WIDTH = 20
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(ROWS)-1:0]  wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(ROWS)-1:0]  rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [ROWS];

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ hdl/segregated_fit_block_allocator_unit.sv @@
`default_nettype none
// Segregated-fit free-block allocator. Raise start with an operation while
// busy is low; exactly one result appears later for one cycle on done, and
// it must be captured then since the block cannot be stalled. An empty or an
// unknown operation goes straight to the done state and an add passes
// through the add state. A small allocate looks at the small classes from
// its own upward, then tries the front entry of each large class; a large
// allocate scans its own class for the best fit, then tries the front
// entries of the higher classes. The block is then unlinked, the tail
// returned and the item finished. The next item may be accepted in the
// cycle that carries the result. List counts live in flip-flops; entries
// live in two synchronous memories with one registered read per cycle.
module segregated_fit_block_allocator_unit #(
    parameter int SMALL_CLASSES   = sfba_pkg::SMALL_CLASSES_DEF,
    parameter int LARGE_CLASSES   = sfba_pkg::LARGE_CLASSES_DEF,
    parameter int LARGE_FIRST_EXP = sfba_pkg::LARGE_FIRST_EXP_DEF,
    parameter int LIST_DEPTH      = sfba_pkg::LIST_DEPTH_DEF,
    parameter int ADDR_BITS       = sfba_pkg::ADDR_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [1:0]                       operation,
    input  wire logic [sfba_pkg::FIELD_BITS-1:0]  size_cells,
    input  wire logic [sfba_pkg::FIELD_BITS-1:0]  block_address,
    output logic                                  done,
    output logic [sfba_pkg::FIELD_BITS-1:0]       granted_address,
    output logic [1:0]                            status,
    output logic [sfba_pkg::FIELD_BITS-1:0]       free_cell_count
);

    import sfba_pkg::*;

    localparam int SCB = (SMALL_CLASSES > 1) ? $clog2(SMALL_CLASSES) : 1;
    localparam int LCB = (LARGE_CLASSES > 1) ? $clog2(LARGE_CLASSES) : 1;
    localparam int IB  = $clog2(LIST_DEPTH);
    localparam int CB  = $clog2(LIST_DEPTH + 1);
    localparam int SROWS = SMALL_CLASSES * LIST_DEPTH;
    localparam int LROWS = LARGE_CLASSES * LIST_DEPTH;
    localparam int SRB = $clog2(SROWS);
    localparam int LRB = $clog2(LROWS);
    localparam int FB  = FIELD_BITS;
    localparam int LW  = ADDR_BITS + FB;
    localparam logic [FB-1:0] FMAX = '1;
    localparam logic [FB-1:0] SMALL_MAX = FB'(SMALL_CLASSES);
    localparam logic [CB-1:0] DEPTH_C = CB'(LIST_DEPTH);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_SSCAN  = 11'b00000000010,
        S_LFRD   = 11'b00000000100,
        S_LFCHK  = 11'b00000001000,
        S_BFRD   = 11'b00000010000,
        S_BFCHK  = 11'b00000100000,
        S_MVRD   = 11'b00001000000,
        S_MVWR   = 11'b00010000000,
        S_CARVE  = 11'b00100000000,
        S_ADD    = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0] scnt_reg [SMALL_CLASSES];
    logic [CB-1:0] lcnt_reg [LARGE_CLASSES];
    logic [FB-1:0] total_reg;

    logic [1:0]           op_reg;
    logic [FB-1:0]        cells_reg;
    logic [ADDR_BITS-1:0] addr_reg;     // block to add
    logic [FB-1:0]        asize_reg;    // size to add
    logic                 is_small_reg; // entry being removed is small
    logic [SCB-1:0]       sc_reg;
    logic [LCB-1:0]       lc_reg;
    logic [IB-1:0]        idx_reg;
    logic                 found_reg;
    logic [IB-1:0]        best_i_reg;
    logic [FB-1:0]        best_sz_reg;
    logic [ADDR_BITS-1:0] best_a_reg;
    logic [ADDR_BITS-1:0] gaddr_reg;
    logic [1:0]           st_reg;
    logic                 done_reg;
    logic                 mv_phase_reg;

    // Memory ports
    logic                 s_we, l_we;
    logic [SRB-1:0]       s_wa, s_ra;
    logic [LRB-1:0]       l_wa, l_ra;
    logic [ADDR_BITS-1:0] s_wd, s_rd;
    logic [LW-1:0]        l_wd, l_rd;
    logic [ADDR_BITS-1:0] l_rd_addr;
    logic [FB-1:0]        l_rd_size;

    assign l_rd_addr = l_rd[LW-1:FB];
    assign l_rd_size = l_rd[FB-1:0];

    sfba_list_mem #(.ROWS(SROWS), .WIDTH(ADDR_BITS)) u_small (
        .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
        .rd_addr(s_ra), .rd_data(s_rd)
    );

    sfba_list_mem #(.ROWS(LROWS), .WIDTH(LW)) u_large (
        .clk(clk), .wr_en(l_we), .wr_addr(l_wa), .wr_data(l_wd),
        .rd_addr(l_ra), .rd_data(l_rd)
    );

    // Large class of a size: floor(log2(size >> exp)), clamped
    function automatic logic [LCB-1:0] large_class(input logic [FB-1:0] cells);
        logic [FB-1:0] v;
        int k;
        v = cells >> LARGE_FIRST_EXP;
        k = 0;
        for (int b = 1; b < FB; b++)
        begin
            if (v[b])
            begin
                k = b;
            end
        end
        if (k > LARGE_CLASSES - 1)
        begin
            k = LARGE_CLASSES - 1;
        end
        return LCB'(k);
    endfunction

    function automatic logic [SRB-1:0] srow(input logic [SCB-1:0] c,
                                            input logic [IB-1:0] i);
        return SRB'(c) * SRB'(LIST_DEPTH) + SRB'(i);
    endfunction

    function automatic logic [LRB-1:0] lrow(input logic [LCB-1:0] c,
                                            input logic [IB-1:0] i);
        return LRB'(c) * LRB'(LIST_DEPTH) + LRB'(i);
    endfunction

    function automatic logic [FB-1:0] sat_add(input logic [FB-1:0] a,
                                              input logic [FB-1:0] b);
        logic [FB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[FB] ? FMAX : s[FB-1:0];
    endfunction

    // Shared decode of the current add target
    logic           add_small;
    logic [SCB-1:0] add_sc;
    logic [LCB-1:0] add_lc;
    logic [CB-1:0]  add_n;
    logic [SCB-1:0] sc_dec;

    assign add_small = (asize_reg <= SMALL_MAX);
    assign sc_dec    = SCB'(asize_reg - FB'(1));
    assign add_sc    = sc_dec;
    assign add_lc    = large_class(asize_reg);
    assign add_n     = add_small ? scnt_reg[add_sc] : lcnt_reg[add_lc];

    logic [CB-1:0] cur_cnt;
    logic [CB-1:0] last_c;
    assign cur_cnt = is_small_reg ? scnt_reg[sc_reg] : lcnt_reg[lc_reg];
    assign last_c  = cur_cnt - CB'(1);

    // Best-fit step on the entry just read; only entries below the count count
    logic          bf_valid, bf_hit, bf_found, bf_stop;
    logic [FB-1:0] bf_best;
    assign bf_valid = (CB'(idx_reg) < lcnt_reg[lc_reg]);
    assign bf_hit   = bf_valid && (l_rd_size >= cells_reg) &&
                      (!found_reg || l_rd_size < best_sz_reg);
    assign bf_found = found_reg || bf_hit;
    assign bf_best  = bf_hit ? l_rd_size : best_sz_reg;
    assign bf_stop  = !bf_valid || (bf_found && bf_best == cells_reg) ||
                      !(CB'(idx_reg) + CB'(1) < lcnt_reg[lc_reg]);

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            done_reg  <= 1'b0;
            for (int c = 0; c < SMALL_CLASSES; c++)
            begin
                scnt_reg[c] <= '0;
            end
            for (int c = 0; c < LARGE_CLASSES; c++)
            begin
                lcnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_DONE);
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        if (operation == OP_EMPTY)
                        begin
                            for (int c = 0; c < SMALL_CLASSES; c++)
                            begin
                                scnt_reg[c] <= '0;
                            end
                            for (int c = 0; c < LARGE_CLASSES; c++)
                            begin
                                lcnt_reg[c] <= '0;
                            end
                        end
                    end
                end
                S_MVWR:
                begin
                    if (is_small_reg)
                    begin
                        scnt_reg[sc_reg] <= last_c;
                    end
                    else
                    begin
                        lcnt_reg[lc_reg] <= last_c;
                    end
                end
                S_CARVE:
                begin
                    // Drop the whole taken block from the count
                    total_reg <= (best_sz_reg > total_reg) ? '0 :
                                 total_reg - best_sz_reg;
                end
                S_ADD:
                begin
                    if (asize_reg != '0 && add_n < DEPTH_C)
                    begin
                        if (add_small)
                        begin
                            scnt_reg[add_sc] <= add_n + CB'(1);
                        end
                        else
                        begin
                            lcnt_reg[add_lc] <= add_n + CB'(1);
                        end
                        total_reg <= sat_add(total_reg, asize_reg);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers and memory addressing
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                op_reg       <= operation;
                cells_reg    <= size_cells;
                addr_reg     <= ADDR_BITS'(block_address);
                asize_reg    <= size_cells;
                gaddr_reg    <= '0;
                st_reg       <= (operation == OP_ALLOC && size_cells == '0) ?
                                ST_NO_FIT : ST_OK;
                found_reg    <= 1'b0;
                idx_reg      <= '0;
                best_sz_reg  <= '0;
                best_i_reg   <= '0;
                sc_reg       <= SCB'(size_cells - FB'(1));
                lc_reg       <= (size_cells <= SMALL_MAX) ? '0 : large_class(size_cells);
                is_small_reg <= (size_cells <= SMALL_MAX);
            end
            S_SSCAN:
            begin
                if (scnt_reg[sc_reg] != '0)
                begin
                    best_i_reg  <= '0;
                    best_sz_reg <= FB'(sc_reg) + FB'(1);
                end
                else if (int'(sc_reg) < SMALL_CLASSES - 1)
                begin
                    sc_reg <= sc_reg + SCB'(1);
                end
                else
                begin
                    is_small_reg <= 1'b0;
                    lc_reg       <= '0;
                end
            end
            S_LFCHK:
            begin
                if (lcnt_reg[lc_reg] != '0 && l_rd_size >= cells_reg)
                begin
                    best_i_reg  <= '0;
                    best_sz_reg <= l_rd_size;
                    best_a_reg  <= l_rd_addr;
                end
                else if (int'(lc_reg) < LARGE_CLASSES - 1)
                begin
                    lc_reg <= lc_reg + LCB'(1);
                end
                else
                begin
                    st_reg <= ST_NO_FIT;
                end
            end
            S_BFCHK:
            begin
                if (bf_hit)
                begin
                    found_reg   <= 1'b1;
                    best_sz_reg <= l_rd_size;
                    best_i_reg  <= idx_reg;
                    best_a_reg  <= l_rd_addr;
                end
                idx_reg <= idx_reg + IB'(1);
                // Own class has no fit: move on to the higher classes
                if (bf_stop && !bf_found)
                begin
                    if (int'(lc_reg) < LARGE_CLASSES - 1)
                    begin
                        lc_reg <= lc_reg + LCB'(1);
                    end
                    else
                    begin
                        st_reg <= ST_NO_FIT;
                    end
                end
            end
            S_MVRD:
            begin
                if (is_small_reg)
                begin
                    best_a_reg <= s_rd;
                end
            end
            S_MVWR:
            begin
                gaddr_reg <= best_a_reg;
            end
            S_CARVE:
            begin
                // Take the whole block, then the tail goes back as an add
                asize_reg <= best_sz_reg - cells_reg;
                addr_reg  <= best_a_reg + ADDR_BITS'(cells_reg);
            end
            S_ADD:
            begin
                if (asize_reg != '0 && add_n >= DEPTH_C)
                begin
                    st_reg <= ST_DROPPED;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Move-last-into-slot and add writes; reads addressed from current regs
    always_comb
    begin
        s_we = 1'b0;
        l_we = 1'b0;
        s_wa = srow(add_sc, IB'(add_n));
        l_wa = lrow(add_lc, IB'(add_n));
        s_wd = addr_reg;
        l_wd = {addr_reg, asize_reg};
        s_ra = srow(sc_reg, best_i_reg);
        l_ra = lrow(lc_reg, idx_reg);
        case (state_reg)
            S_LFRD:
            begin
                l_ra = lrow(lc_reg, '0);
            end
            S_MVRD:
            begin
                // Read the front (small) and, later, the last entry
                s_ra = mv_phase_reg ? srow(sc_reg, IB'(last_c)) : srow(sc_reg, '0);
                l_ra = lrow(lc_reg, IB'(last_c));
            end
            S_MVWR:
            begin
                s_wa = srow(sc_reg, '0);
                s_wd = s_rd;
                l_wa = lrow(lc_reg, best_i_reg);
                l_wd = l_rd;
                s_we = is_small_reg;
                l_we = !is_small_reg;
            end
            S_ADD:
            begin
                if (asize_reg != '0 && add_n < DEPTH_C)
                begin
                    s_we = add_small;
                    l_we = !add_small;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Small path needs the last entry too: fetch it in a second read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mv_phase_reg <= 1'b0;
        end
        else if (state_reg == S_MVRD)
        begin
            mv_phase_reg <= ~mv_phase_reg;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_ALLOC && size_cells != '0)
                    begin
                        state_next = (size_cells <= SMALL_MAX) ? S_SSCAN : S_BFRD;
                    end
                    else if (operation == OP_ADD)
                    begin
                        state_next = S_ADD;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SSCAN:
            begin
                if (scnt_reg[sc_reg] != '0)
                begin
                    state_next = S_MVRD;
                end
                else if (int'(sc_reg) >= SMALL_CLASSES - 1)
                begin
                    state_next = S_LFRD;
                end
            end
            S_LFRD:
            begin
                state_next = S_LFCHK;
            end
            S_LFCHK:
            begin
                if (lcnt_reg[lc_reg] != '0 && l_rd_size >= cells_reg)
                begin
                    state_next = S_MVRD;
                end
                else if (int'(lc_reg) < LARGE_CLASSES - 1)
                begin
                    state_next = S_LFRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_BFRD:
            begin
                state_next = S_BFCHK;
            end
            S_BFCHK:
            begin
                if (!bf_stop)
                begin
                    state_next = S_BFRD;
                end
                else if (bf_found)
                begin
                    state_next = S_MVRD;
                end
                else
                begin
                    state_next = (int'(lc_reg) < LARGE_CLASSES - 1) ? S_LFRD : S_DONE;
                end
            end
            S_MVRD:
            begin
                state_next = mv_phase_reg ? S_MVWR : S_MVRD;
            end
            S_MVWR:
            begin
                state_next = S_CARVE;
            end
            S_CARVE:
            begin
                state_next = (best_sz_reg != cells_reg) ? S_ADD : S_DONE;
            end
            S_ADD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign granted_address = (op_reg == OP_ALLOC && st_reg != ST_NO_FIT) ?
                             FB'(gaddr_reg) : '0;
    assign status          = st_reg;
    assign free_cell_count = total_reg;

endmodule
`default_nettype wire

@@ verif/segregated_fit_block_allocator_unit_tb.sv @@
`default_nettype none
module segregated_fit_block_allocator_unit_tb;
    import sfba_pkg::*;

    localparam int NSMALL = SMALL_CLASSES_DEF;
    localparam int NLARGE = LARGE_CLASSES_DEF;
    localparam int LEXP   = LARGE_FIRST_EXP_DEF;
    localparam int DEPTH  = LIST_DEPTH_DEF;
    localparam logic [19:0] FMAX = 20'hFFFFF;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [19:0] addr;
        logic [1:0]  st;
        logic [19:0] total;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  operation;
    logic [19:0] size_cells;
    logic [19:0] block_address;
    logic        done;
    logic [19:0] granted_address;
    logic [1:0]  status;
    logic [19:0] free_cell_count;

    // shadow of the allocator's lists
    logic [19:0] small_addr [NSMALL][DEPTH];
    int          small_cnt  [NSMALL];
    logic [19:0] large_addr [NLARGE][DEPTH];
    logic [19:0] large_size [NLARGE][DEPTH];
    int          large_cnt  [NLARGE];
    logic [19:0] free_total;

    alloc_result_t pending_results[$];
    int  mismatches;
    int  cycles;
    bit  idle_on;

    segregated_fit_block_allocator_unit u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .operation(operation), .size_cells(size_cells),
        .block_address(block_address), .done(done),
        .granted_address(granted_address), .status(status),
        .free_cell_count(free_cell_count)
    );

    always #4 clk = ~clk;

    function automatic int class_of_large(logic [19:0] cells);
        logic [19:0] v;
        int k;
        v = cells >> LEXP;
        k = 0;
        while (v > 1)
        begin
            v = v >> 1;
            k++;
        end
        return (k > NLARGE - 1) ? NLARGE - 1 : k;
    endfunction

    function automatic void total_add(logic [19:0] n);
        logic [20:0] s;
        s = {1'b0, free_total} + {1'b0, n};
        free_total = (s > {1'b0, FMAX}) ? FMAX : s[19:0];
    endfunction

    function automatic void total_sub(logic [19:0] n);
        free_total = (n > free_total) ? 20'd0 : free_total - n;
    endfunction

    function automatic bit keep_block(logic [19:0] a, logic [19:0] cells);
        int c;
        if (cells <= NSMALL)
        begin
            c = int'(cells) - 1;
            if (small_cnt[c] >= DEPTH) return 0;
            small_addr[c][small_cnt[c]] = a;
            small_cnt[c]++;
        end
        else
        begin
            c = class_of_large(cells);
            if (large_cnt[c] >= DEPTH) return 0;
            large_addr[c][large_cnt[c]] = a;
            large_size[c][large_cnt[c]] = cells;
            large_cnt[c]++;
        end
        total_add(cells);
        return 1;
    endfunction

    function automatic void drop_large(int c, int i);
        int last;
        last = large_cnt[c] - 1;
        if (i < last)
        begin
            large_addr[c][i] = large_addr[c][last];
            large_size[c][i] = large_size[c][last];
        end
        large_cnt[c] = last;
    endfunction

    // take a block and return its unused tail to the lists
    function automatic void split_tail(logic [19:0] a, logic [19:0] blk,
                                       logic [19:0] cells, ref logic [1:0] st);
        logic [19:0] rem;
        rem = blk - cells;
        total_sub(blk);
        if (rem > 0 && !keep_block(a + cells, rem)) st = ST_DROPPED;
    endfunction

    function automatic bit take_first_large(int from, logic [19:0] cells,
                                            ref logic [19:0] a, ref logic [1:0] st);
        logic [19:0] ea, es;
        for (int c = from; c < NLARGE; c++)
        begin
            if (large_cnt[c] > 0 && large_size[c][0] >= cells)
            begin
                ea = large_addr[c][0];
                es = large_size[c][0];
                drop_large(c, 0);
                split_tail(ea, es, cells, st);
                a = ea;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit find_block(logic [19:0] cells, ref logic [19:0] a,
                                      ref logic [1:0] st);
        int c, best_i, last;
        logic [19:0] best_sz, ea;
        bit found;
        if (cells == 0) return 0;
        if (cells <= NSMALL)
        begin
            for (c = int'(cells) - 1; c < NSMALL; c++)
            begin
                if (small_cnt[c] > 0)
                begin
                    ea = small_addr[c][0];
                    last = small_cnt[c] - 1;
                    if (last > 0) small_addr[c][0] = small_addr[c][last];
                    small_cnt[c] = last;
                    split_tail(ea, 20'(c + 1), cells, st);
                    a = ea;
                    return 1;
                end
            end
            return take_first_large(0, cells, a, st);
        end
        // best fit within own class, stop on exact match
        c = class_of_large(cells);
        found = 0;
        best_i = 0;
        best_sz = '0;
        for (int i = 0; i < large_cnt[c]; i++)
        begin
            if (large_size[c][i] >= cells && (!found || large_size[c][i] < best_sz))
            begin
                found = 1;
                best_sz = large_size[c][i];
                best_i = i;
            end
            if (found && best_sz == cells) break;
        end
        if (found)
        begin
            ea = large_addr[c][best_i];
            drop_large(c, best_i);
            split_tail(ea, best_sz, cells, st);
            a = ea;
            return 1;
        end
        return take_first_large(c + 1, cells, a, st);
    endfunction

    function automatic alloc_result_t predict_item(logic [1:0] op, logic [19:0] cells,
                                                   logic [19:0] baddr);
        alloc_result_t r;
        logic [19:0] a;
        logic [1:0] st;
        a = '0;
        st = ST_OK;
        r.addr = '0;
        if (op == OP_ALLOC)
        begin
            if (find_block(cells, a, st)) r.addr = a;
            else st = ST_NO_FIT;
        end
        else if (op == OP_ADD)
        begin
            if (cells > 0 && !keep_block(baddr, cells)) st = ST_DROPPED;
        end
        else if (op == OP_EMPTY)
        begin
            for (int i = 0; i < NSMALL; i++) small_cnt[i] = 0;
            for (int i = 0; i < NLARGE; i++) large_cnt[i] = 0;
        end
        r.st = st;
        r.total = free_total;
        return r;
    endfunction

    // send one item, with a random idle gap before it when idle gaps are on
    task automatic send_item(logic [1:0] op, logic [19:0] cells, logic [19:0] baddr);
        while (idle_on && $urandom_range(99) < 27) @(posedge clk);
        start <= 1'b1;
        operation <= op;
        size_cells <= cells;
        block_address <= baddr;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(predict_item(op, cells, baddr));
        start <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        while (pending_results.size() > 0) @(posedge clk);
    endtask

    // check each result against the oldest expectation
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result addr=%h", granted_address);
            end
            else
            begin
                e = pending_results.pop_front();
                if (e.addr !== granted_address || e.st !== status ||
                    e.total !== free_cell_count)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp addr=%h st=%0d tot=%h got addr=%h st=%0d tot=%h",
                                 e.addr, e.st, e.total, granted_address, status,
                                 free_cell_count);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic test_edges();
        send_item(OP_ALLOC, 20'd0, 20'd0);
        send_item(OP_ALLOC, 20'd5, 20'd0);
        send_item(OP_ADD, 20'd0, 20'h12345);
        send_item(OP_ADD, 20'd1, 20'hFFFFF);
        send_item(OP_ADD, 20'd31, 20'h00010);
        send_item(OP_ADD, 20'd32, 20'h00100);
        send_item(OP_ADD, 20'hFFFFF, 20'h00000);
        send_item(OP_ADD, 20'hFFFFF, 20'hAAAAA);
        send_item(OP_ALLOC, 20'd1, 20'd0);
        send_item(OP_ALLOC, 20'd3, 20'd0);
        send_item(OP_ALLOC, 20'd32, 20'd0);
        send_item(OP_ALLOC, 20'h80000, 20'd0);
        send_item(OP_ALLOC, 20'hFFFFF, 20'd0);
        send_item(2'd3, 20'h55555, 20'h55555);
        send_item(OP_EMPTY, 20'd0, 20'd0);
        send_item(OP_ALLOC, 20'd1, 20'd0);
    endtask

    // fill lists to overflow, including split tails into a full list
    task automatic test_full_lists();
        for (int i = 0; i < DEPTH + 2; i++) send_item(OP_ADD, 20'd2, 20'(i * 4));
        for (int i = 0; i < DEPTH + 1; i++)
            send_item(OP_ADD, 20'd100, 20'(32'h1000 + i * 128));
        send_item(OP_ALLOC, 20'd98, 20'd0);
        send_item(OP_ALLOC, 20'd100, 20'd0);
        send_item(OP_EMPTY, 20'd0, 20'd0);
    endtask

    task automatic test_random(int n, bit idle);
        logic [1:0] op;
        logic [19:0] cells;
        int r;
        idle_on = idle;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 2) op = OP_EMPTY;
            else if (r < 3) op = 2'd3;
            else if (r < 50) op = OP_ADD;
            else op = OP_ALLOC;
            r = $urandom_range(99);
            if (r < 50) cells = 20'($urandom_range(40));
            else if (r < 90) cells = 20'($urandom_range(1500, 32));
            else cells = 20'($urandom);
            send_item(op, cells, 20'($urandom));
        end
        idle_on = 1;
    endtask

    initial
    begin
        clk = 0;
        rst_n = 0;
        start = 0;
        operation = OP_ALLOC;
        size_cells = 0;
        block_address = 0;
        mismatches = 0;
        cycles = 0;
        idle_on = 1;
        free_total = 0;
        for (int i = 0; i < NSMALL; i++) small_cnt[i] = 0;
        for (int i = 0; i < NLARGE; i++) large_cnt[i] = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_edges();
        test_full_lists();
        test_random(700, 1);
        // hold until the block has returned everything
        drain_results();
        test_random(300, 0);
        test_random(500, 1);
        drain_results();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
